>>> rtl/fdes_pkg.sv
// Package for the FAT directory entry scanner: row and field widths,
// entry byte codes and the long-name character conversion. No dependencies.
`default_nettype none
package fdes_pkg;
  localparam int unsigned CharsPerPart = 13;
  localparam int unsigned RowW         = 8 * CharsPerPart;
  localparam int unsigned EntryW       = 256;
  localparam int unsigned PartCntW     = 5;

  localparam logic [7:0] EndMark    = 8'h00;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] AttrLfn    = 8'h0F;
  localparam logic [7:0] AttrVolBit = 8'h08;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTilde    = 8'h7E;
  localparam logic [7:0] ChUnder    = 8'h5F;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [15:0] Ucs2Nul   = 16'h0000;
  localparam logic [15:0] Ucs2Pad   = 16'hFFFF;

  // Byte offset of each UCS-2 character inside a long-name slot.
  localparam logic [4:0] PartCharOffset [CharsPerPart] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
    5'd28, 5'd30
  };

  // Terminators become zero, printable ASCII is kept, anything else is '_'.
  function automatic logic [7:0] to_ascii(input logic [15:0] c);
    logic [7:0] r;
    if (c == Ucs2Nul || c == Ucs2Pad) r = 8'h00;
    else if (c >= {8'h00, ChSpace} && c <= {8'h00, ChTilde}) r = c[7:0];
    else r = ChUnder;
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/fdes_name_ram.sv
// Long-name store: one row of thirteen characters per long-name part.
// One write and one read port, read data registered. Uses fdes_pkg.
`default_nettype none
module fdes_name_ram #(
  parameter int unsigned Depth = 20,
  parameter int unsigned AddrW = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire logic [fdes_pkg::RowW-1:0] wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output logic      [fdes_pkg::RowW-1:0] rdata_o
);
  import fdes_pkg::*;

  logic [RowW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/fat_directory_entry_scanner_unit.sv
// FAT directory entry scanner top level; uses fdes_pkg and fdes_name_ram.
// A not-found status item is valid at the output the cycle after its entry is taken.
// Throughput: entries that do not match are taken one per cycle, back to back while the
// output register can take an item. A match then holds the input while each long-name
// part is read, each character is sent, each field ended early by a space, terminator
// or the length limit is closed, the status item is sent, and during any output stall.
`default_nettype none
module fat_directory_entry_scanner_unit #(
  parameter int unsigned LONG_PARTS = 20,
  parameter int unsigned NAME_LIMIT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] entry_word0_i,
  input  wire logic [63:0] entry_word1_i,
  input  wire logic [63:0] entry_word2_i,
  input  wire logic [63:0] entry_word3_i,
  input  wire logic        first_of_scan_i,
  input  wire logic        last_of_dir_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_name_char_o,
  output logic [7:0]       name_char_o,
  output logic             status_o,
  output logic [7:0]       found_attr_o,
  output logic [31:0]      found_cluster_o,
  output logic [31:0]      found_size_o,
  output logic [15:0]      raw_position_o,
  output logic             last_of_run_o
);
  import fdes_pkg::*;

  localparam int unsigned PartAW = (LONG_PARTS > 1) ? $clog2(LONG_PARTS) : 1;
  localparam int unsigned NameW  = $clog2(NAME_LIMIT) + 1;

  typedef enum logic [2:0] {S_IDLE, S_LRD, S_LCH, S_SFN, S_FIN} state_e;

  state_e              state_q, state_d;
  logic [15:0]         wanted_q;
  logic [15:0]         vis_q, vis_d, slot_q, slot_d;
  logic [PartCntW-1:0] lpc_q, lpc_d;
  logic                done_q, done_d;
  logic [EntryW-1:0]   ent_q, ent_d, ent_in;
  logic [PartAW-1:0]   part_q, part_d;
  logic [3:0]          chi_q, chi_d;
  logic [NameW-1:0]    n_q, n_d;

  logic        ov_q, ov_d, oc_q, oc_d, ost_q, ost_d, olast_q, olast_d;
  logic [7:0]  och_q, och_d, oattr_q, oattr_d;
  logic [31:0] oclu_q, oclu_d, osize_q, osize_d;
  logic [15:0] oraw_q, oraw_d;

  logic              can_put;
  logic              ram_we, ram_re;
  logic [RowW-1:0]   ram_wdata, ram_rdata;
  logic [7:0]        b0, battr, cur_ch, sfn_ch;
  logic [NameW-1:0]  n_next;

  // The entry as one flat little-endian byte vector.
  assign ent_in = {entry_word3_i, entry_word2_i, entry_word1_i, entry_word0_i};
  assign b0     = ent_in[7:0];
  assign battr  = ent_in[95:88];

  // Convert the thirteen UCS-2 characters of a long-name slot to one row.
  always_comb begin
    for (int k = 0; k < CharsPerPart; k++) begin
      ram_wdata[8*k +: 8] =
        to_ascii(ent_in[8*PartCharOffset[k] +: 16]);
    end
  end

  // A slot that opens a new scan is stored as its first part.
  fdes_name_ram #(.Depth(LONG_PARTS), .AddrW(PartAW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (first_of_scan_i ? '0 : lpc_q[PartAW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (part_q),
    .rdata_o (ram_rdata)
  );

  // The output register can take an item when empty or being emptied.
  assign can_put     = !ov_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !can_put;
  assign cfg_ready_o = 1'b1;

  assign cur_ch = ram_rdata[8*chi_q +: 8];
  assign sfn_ch = ent_q[8*chi_q +: 8];
  assign n_next = n_q + NameW'(1);

  always_comb begin
    state_d = state_q;
    vis_d   = vis_q;
    slot_d  = slot_q;
    lpc_d   = lpc_q;
    done_d  = done_q;
    ent_d   = ent_q;
    part_d  = part_q;
    chi_d   = chi_q;
    n_d     = n_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    ov_d    = ov_q && out_stall_i;
    oc_d    = oc_q;
    och_d   = och_q;
    ost_d   = ost_q;
    oattr_d = oattr_q;
    oclu_d  = oclu_q;
    osize_d = osize_q;
    oraw_d  = oraw_q;
    olast_d = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          ent_d = ent_in;
          if (first_of_scan_i) begin
            vis_d  = '0;
            slot_d = '0;
            lpc_d  = '0;
            done_d = 1'b0;
          end
          if (!done_d) begin
            if (b0 == EndMark) begin
              ov_d    = 1'b1;
              oc_d    = 1'b0;
              och_d   = '0;
              ost_d   = 1'b1;
              oattr_d = '0;
              oclu_d  = '0;
              osize_d = '0;
              oraw_d  = '0;
              olast_d = 1'b1;
              done_d  = 1'b1;
            end else begin
              priority if (b0 == DeletedMark) begin
                lpc_d = '0;
              end else if (battr == AttrLfn) begin
                if (lpc_d < PartCntW'(LONG_PARTS)) begin
                  ram_we = 1'b1;
                  lpc_d  = lpc_d + PartCntW'(1);
                end
              end else if ((battr & AttrVolBit) != 8'h00) begin
                lpc_d = '0;
              end else if (vis_d == wanted_q) begin
                // The match: the name is streamed out, then the status item.
                n_d    = '0;
                chi_d  = '0;
                part_d = PartAW'(lpc_d - PartCntW'(1));
                state_d = (lpc_d != '0) ? S_LRD : S_SFN;
              end else begin
                vis_d = vis_d + 16'd1;
                lpc_d = '0;
              end
              if (state_d == S_IDLE) begin
                slot_d = slot_d + 16'd1;
                if (last_of_dir_i) begin
                  ov_d    = 1'b1;
                  oc_d    = 1'b0;
                  och_d   = '0;
                  ost_d   = 1'b1;
                  oattr_d = '0;
                  oclu_d  = '0;
                  osize_d = '0;
                  oraw_d  = '0;
                  olast_d = 1'b1;
                  done_d  = 1'b1;
                end
              end
            end
          end
        end
      end
      S_LRD: begin
        ram_re  = 1'b1;
        chi_d   = '0;
        state_d = S_LCH;
      end
      S_LCH: begin
        if (can_put) begin
          if (n_next >= NameW'(NAME_LIMIT) || cur_ch == 8'h00) begin
            state_d = S_FIN;
          end else begin
            ov_d    = 1'b1;
            oc_d    = 1'b1;
            och_d   = cur_ch;
            ost_d   = 1'b0;
            oattr_d = '0;
            oclu_d  = '0;
            osize_d = '0;
            oraw_d  = '0;
            olast_d = 1'b0;
            n_d     = n_next;
            chi_d   = chi_q + 4'd1;
            if (chi_q == 4'(CharsPerPart - 1)) begin
              if (part_q == '0) begin
                state_d = S_FIN;
              end else begin
                part_d  = part_q - PartAW'(1);
                state_d = S_LRD;
              end
            end
          end
        end
      end
      S_SFN: begin
        // Steps 0..7 base name, 8 the dot, 9..11 the extension.
        if (can_put) begin
          if (chi_q < 4'd8) begin
            if (sfn_ch == ChSpace) begin
              chi_d = 4'd8;
            end else begin
              ov_d  = 1'b1;
              och_d = sfn_ch;
              chi_d = chi_q + 4'd1;
            end
          end else if (chi_q == 4'd8) begin
            if (ent_q[71:64] == ChSpace) begin
              state_d = S_FIN;
            end else begin
              ov_d  = 1'b1;
              och_d = ChDot;
              chi_d = 4'd9;
            end
          end else begin
            if (ent_q[8*(chi_q-4'd1) +: 8] == ChSpace) begin
              state_d = S_FIN;
            end else begin
              ov_d  = 1'b1;
              och_d = ent_q[8*(chi_q-4'd1) +: 8];
              chi_d = chi_q + 4'd1;
              if (chi_q == 4'd11) state_d = S_FIN;
            end
          end
          oc_d    = 1'b1;
          ost_d   = 1'b0;
          oattr_d = '0;
          oclu_d  = '0;
          osize_d = '0;
          oraw_d  = '0;
          olast_d = 1'b0;
        end
      end
      S_FIN: begin
        if (can_put) begin
          ov_d    = 1'b1;
          oc_d    = 1'b0;
          och_d   = '0;
          ost_d   = 1'b0;
          oattr_d = ent_q[95:88];
          oclu_d  = {ent_q[175:160], ent_q[223:208]};
          osize_d = ent_q[255:224];
          oraw_d  = slot_q;
          olast_d = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wanted_q <= '0;
      vis_q    <= '0;
      slot_q   <= '0;
      lpc_q    <= '0;
      done_q   <= 1'b0;
      ov_q     <= 1'b0;
      ent_q    <= '0;
      part_q   <= '0;
      chi_q    <= '0;
      n_q      <= '0;
      oc_q     <= 1'b0;
      och_q    <= '0;
      ost_q    <= 1'b0;
      oattr_q  <= '0;
      oclu_q   <= '0;
      osize_q  <= '0;
      oraw_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) wanted_q <= cfg_data_i;
      vis_q   <= vis_d;
      slot_q  <= slot_d;
      lpc_q   <= lpc_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
      ent_q   <= ent_d;
      part_q  <= part_d;
      chi_q   <= chi_d;
      n_q     <= n_d;
      oc_q    <= oc_d;
      och_q   <= och_d;
      ost_q   <= ost_d;
      oattr_q <= oattr_d;
      oclu_q  <= oclu_d;
      osize_q <= osize_d;
      oraw_q  <= oraw_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign is_name_char_o  = oc_q;
  assign name_char_o     = och_q;
  assign status_o        = ost_q;
  assign found_attr_o    = oattr_q;
  assign found_cluster_o = oclu_q;
  assign found_size_o    = osize_q;
  assign raw_position_o  = oraw_q;
  assign last_of_run_o   = olast_q;

  a_part_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lpc_q <= PartCntW'(LONG_PARTS))
    else $error("long-name part count above capacity");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("entry taken while a name is being streamed");
  a_name_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LCH |-> n_q < NameW'(NAME_LIMIT))
    else $error("name length beyond limit");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && can_put) |=> done_q && ov_q && last_of_run_o)
    else $error("status item missing after name");
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the FAT directory entry scanner top level.
// Feeds directed and random directory scans and checks every output item
// against an in-bench model of the scan. Depends on fdes_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import fdes_pkg::*;

  localparam int unsigned PartsMax  = 20;
  localparam int unsigned NameMax   = 64;
  localparam int unsigned ItemGoal  = 310;
  localparam int unsigned LongHold  = 250;

  typedef struct packed {
    logic        is_char;
    logic [7:0]  ch;
    logic        not_found;
    logic [7:0]  attr;
    logic [31:0] cluster;
    logic [31:0] size;
    logic [15:0] raw;
    logic        last;
  } scan_res_t;

  typedef struct {
    logic [255:0] ent;
    bit           first;
    bit           last;
    bit           typed_nf;  // expected: one plain not-found item
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] word0, word1, word2, word3;
  logic        first_scan, last_dir;
  logic        out_valid;
  logic        out_stall;
  logic        o_is_char;
  logic [7:0]  o_char;
  logic        o_status;
  logic [7:0]  o_attr;
  logic [31:0] o_cluster;
  logic [31:0] o_size;
  logic [15:0] o_raw;
  logic        o_last;

  // Scan model state.
  logic [15:0] want_idx;
  logic [15:0] vis_cnt;
  logic [15:0] slot_cnt;
  int unsigned part_cnt;
  logic [7:0]  lfn_chars [PartsMax*CharsPerPart];
  bit          scan_done;

  scan_res_t   dir_results_q [$];
  int unsigned err_cnt;
  int unsigned sent_cnt;
  bit          calm;
  bit          hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fat_directory_entry_scanner_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .entry_word0_i   (word0),
    .entry_word1_i   (word1),
    .entry_word2_i   (word2),
    .entry_word3_i   (word3),
    .first_of_scan_i (first_scan),
    .last_of_dir_i   (last_dir),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .is_name_char_o  (o_is_char),
    .name_char_o     (o_char),
    .status_o        (o_status),
    .found_attr_o    (o_attr),
    .found_cluster_o (o_cluster),
    .found_size_o    (o_size),
    .raw_position_o  (o_raw),
    .last_of_run_o   (o_last)
  );

  function automatic logic [7:0] ucs_to_char(logic [15:0] c);
    if (c == 16'h0000 || c == 16'hFFFF) return 8'h00;
    if (c >= 16'h0020 && c <= 16'h007E) return c[7:0];
    return ChUnder;
  endfunction

  function automatic scan_res_t char_res(logic [7:0] c);
    scan_res_t r;
    r = '0;
    r.is_char = 1'b1;
    r.ch = c;
    return r;
  endfunction

  function automatic scan_res_t miss_res();
    scan_res_t r;
    r = '0;
    r.not_found = 1'b1;
    r.last = 1'b1;
    return r;
  endfunction

  // Works out what one accepted entry produces and moves the model state on.
  function automatic void scan_entry(input logic [255:0] e, input bit first,
                                     input bit last, output scan_res_t r[$]);
    logic [7:0] b0, attr, c;
    scan_res_t  fin;
    bit         stop;
    r = {};
    if (first) begin
      vis_cnt = '0;
      slot_cnt = '0;
      part_cnt = 0;
      scan_done = 0;
    end
    if (scan_done) return;
    b0 = e[7:0];
    attr = e[95:88];
    if (b0 == EndMark) begin
      r.push_back(miss_res());
      scan_done = 1;
      return;
    end
    if (b0 == DeletedMark) begin
      part_cnt = 0;
    end else if (attr == AttrLfn) begin
      if (part_cnt < PartsMax) begin
        for (int i = 0; i < CharsPerPart; i++)
          lfn_chars[part_cnt*CharsPerPart + i] =
            ucs_to_char(e[8*PartCharOffset[i] +: 16]);
        part_cnt++;
      end
    end else if ((attr & AttrVolBit) != 0) begin
      part_cnt = 0;
    end else if (vis_cnt == want_idx) begin
      stop = 0;
      if (part_cnt > 0) begin
        // Long name, last stored part first, capped one short of the limit.
        for (int p = int'(part_cnt) - 1; p >= 0 && !stop; p--)
          for (int i = 0; i < CharsPerPart && !stop; i++) begin
            c = lfn_chars[p*CharsPerPart + i];
            if (r.size() + 1 >= NameMax || c == 8'h00) stop = 1;
            else r.push_back(char_res(c));
          end
      end else begin
        for (int i = 0; i < 8 && !stop; i++) begin
          if (e[8*i +: 8] == ChSpace) stop = 1;
          else r.push_back(char_res(e[8*i +: 8]));
        end
        if (e[71:64] != ChSpace) begin
          r.push_back(char_res(ChDot));
          stop = 0;
          for (int i = 8; i < 11 && !stop; i++) begin
            if (e[8*i +: 8] == ChSpace) stop = 1;
            else r.push_back(char_res(e[8*i +: 8]));
          end
        end
      end
      fin = '0;
      fin.attr = attr;
      fin.cluster = {e[175:168], e[167:160], e[223:216], e[215:208]};
      fin.size = e[255:224];
      fin.raw = slot_cnt;
      fin.last = 1'b1;
      r.push_back(fin);
      scan_done = 1;
      return;
    end else begin
      vis_cnt++;
      part_cnt = 0;
    end
    slot_cnt++;
    if (last) begin
      r.push_back(miss_res());
      scan_done = 1;
    end
  endfunction

  // Entry builders. Unused bytes are random.
  function automatic logic [255:0] rand_bits();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [255:0] short_entry(string nm, logic [7:0] attr,
                                               logic [31:0] clus,
                                               logic [31:0] sz);
    logic [255:0] e;
    e = rand_bits();
    for (int k = 0; k < 11; k++) e[8*k +: 8] = nm[k];
    e[95:88] = attr;
    e[175:160] = clus[31:16];
    e[223:208] = clus[15:0];
    e[255:224] = sz;
    return e;
  endfunction

  function automatic logic [255:0] lfn_entry(logic [15:0] ch [CharsPerPart]);
    logic [255:0] e;
    e = rand_bits();
    e[7:0] = 8'h41;
    e[95:88] = AttrLfn;
    for (int i = 0; i < CharsPerPart; i++) e[8*PartCharOffset[i] +: 16] = ch[i];
    return e;
  endfunction

  function automatic logic [255:0] lfn_text(string s);
    logic [15:0] ch [CharsPerPart];
    for (int i = 0; i < CharsPerPart; i++)
      ch[i] = (i < s.len()) ? {8'h00, s[i]} : ((i == s.len()) ? 16'h0000 : 16'hFFFF);
    return lfn_entry(ch);
  endfunction

  function automatic logic [255:0] rand_lfn();
    logic [15:0] ch [CharsPerPart];
    for (int i = 0; i < CharsPerPart; i++) begin
      case ($urandom_range(0, 19))
        0:       ch[i] = 16'($urandom);
        1:       ch[i] = (i > 3) ? 16'hFFFF : 16'h0041;
        2:       ch[i] = (i > 3) ? 16'h0000 : 16'h007E;
        default: ch[i] = 16'($urandom_range(16'h20, 16'h7E));
      endcase
    end
    return lfn_entry(ch);
  endfunction

  function automatic logic [255:0] rand_short();
    logic [255:0] e;
    e = rand_bits();
    for (int k = 0; k < 11; k++)
      e[8*k +: 8] = ($urandom_range(0, 5) == 0) ? ChSpace : 8'($urandom_range(8'h21, 8'h7E));
    if ($urandom_range(0, 7) == 0) e[7:0] = 8'($urandom);
    if (e[7:0] == EndMark || e[7:0] == DeletedMark || e[7:0] == ChSpace) e[7:0] = 8'h80;
    e[91] = 1'b0;  // attribute without the volume bit, so never a long-name part
    return e;
  endfunction

  function automatic logic [255:0] rand_noise();
    logic [255:0] e;
    e = rand_bits();
    case ($urandom_range(0, 2))
      0: e[7:0] = DeletedMark;
      1: begin
        if (e[7:0] == EndMark || e[7:0] == DeletedMark) e[7:0] = 8'h7F;
        e[91] = 1'b1;
        if (e[95:88] == AttrLfn) e[95:88] = 8'h08;
      end
      default: if (e[7:0] == EndMark) e[7:0] = 8'hFF;
    endcase
    return e;
  endfunction

  task automatic check_field(string nm, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", nm, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Output monitor: every accepted item is checked against the oldest one due.
  always @(posedge clk) begin
    scan_res_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (dir_results_q.size() == 0) begin
        $error("output item with none expected");
        err_cnt++;
      end else begin
        x = dir_results_q.pop_front();
        check_field("is_name_char", x.is_char, o_is_char);
        check_field("name_char", x.ch, o_char);
        check_field("status", x.not_found, o_status);
        check_field("found_attr", x.attr, o_attr);
        check_field("found_cluster", x.cluster, o_cluster);
        check_field("found_size", x.size, o_size);
        check_field("raw_position", x.raw, o_raw);
        check_field("last_of_run", x.last, o_last);
      end
    end
  end

  // Receiver: a random stall before each item, none in calm stretches, and one
  // long hold-off on request so that the scanner backs up into its input.
  initial begin
    int unsigned n;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        n = LongHold;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_entry(logic [255:0] e, bit first, bit last, bit typed_nf = 0);
    int unsigned gap;
    scan_res_t   r [$];
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {word3, word2, word1, word0} <= e;
    first_scan <= first;
    last_dir <= last;
    do @(posedge clk); while (in_stall);
    scan_entry(e, first, last, r);
    if (typed_nf) r = '{miss_res()};
    foreach (r[i]) dir_results_q.push_back(r[i]);
    sent_cnt++;
  endtask

  // Registers are only written once the scanner has drained.
  task automatic set_wanted(logic [15:0] v);
    in_valid <= 1'b0;
    wait (dir_results_q.size() == 0);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    want_idx = v;
  endtask

  // One random scan: visible entries with optional long-name parts and noise,
  // closed by an end marker or the directory's last entry.
  task automatic random_scan(int unsigned nvis, bit force_overflow);
    int unsigned parts;
    bit          first;
    first = 1;
    for (int v = 0; v <= nvis && !scan_done || first; v++) begin
      repeat ($urandom_range(0, 1)) begin
        send_entry(rand_noise(), first, 0);
        first = 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: parts = 0;
        4:          parts = $urandom_range(5, 6);
        default:    parts = $urandom_range(1, 3);
      endcase
      if (force_overflow) parts = PartsMax + 1;
      for (int p = 0; p < parts && !(scan_done && !first); p++) begin
        send_entry(rand_lfn(), first || ($urandom_range(0, 99) == 0), 0);
        first = 0;
      end
      if (scan_done) break;
      send_entry(rand_short(), first, (v == nvis) && $urandom_range(0, 1));
      first = 0;
    end
    if (!scan_done) send_entry(rand_noise() & ~256'hFF, 0, 0);
  endtask

  initial begin
    dir_row_t rows [$];
    logic [15:0] ws;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    {word3, word2, word1, word0} = '0;
    first_scan = 1'b0;
    last_dir = 1'b0;
    out_stall = 1'b0;
    calm = 0;
    hold_req = 0;
    err_cnt = 0;
    sent_cnt = 0;
    want_idx = '0;
    vis_cnt = '0;
    slot_cnt = '0;
    part_cnt = 0;
    scan_done = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scans with the reset setting: index 0.
    rows = '{
      '{256'h0, 1, 0, 1},                                                 // end marker
      '{short_entry("FILE    TXT", 8'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 0, 0},
      '{short_entry("NOEXT      ", 8'h00, 32'h0, 32'h0), 1, 0, 0},            // no extension
      '{short_entry("ABCDEFGHI  ", 8'hF7, 32'h1234_5678, 32'h9), 1, 0, 0},
      '{lfn_text("tail.txt"), 1, 0, 0},                                     // long name
      '{lfn_text("Long\351"), 0, 0, 0},                                     // non-ASCII char
      '{short_entry("LONGNA~1TXT", 8'h20, 32'h2, 32'h3), 0, 0, 0},
      '{lfn_text("gone"), 1, 0, 0},                                          // deleted drops parts
      '{short_entry("\345ELETED TXT", 8'h20, 32'h0, 32'h0), 0, 0, 0},
      '{short_entry("VOLUME     ", 8'h08, 32'h0, 32'h0), 0, 1, 1},            // label, last of dir
      '{short_entry("IGNORED TXT", 8'h20, 32'h0, 32'h0), 0, 0, 0},            // after done
      '{lfn_text(""), 1, 0, 0},                                              // empty name
      '{short_entry("EMPTY   BIN", 8'h01, 32'h5, 32'h6), 0, 1, 0}
    };
    foreach (rows[i]) send_entry(rows[i].ent, rows[i].first, rows[i].last, rows[i].typed_nf);

    set_wanted(16'hFFFF);  // never reached: scans end in not-found
    send_entry(short_entry("A       B  ", 8'h10, 32'h1, 32'h1), 1, 0);
    send_entry(short_entry("B          ", 8'h00, 32'h1, 32'h1), 0, 1, 1);
    send_entry(short_entry("C          ", 8'h00, 32'h1, 32'h1), 1, 0);
    send_entry(256'h0, 0, 0, 1);

    set_wanted(16'd2);
    send_entry(short_entry("ONE        ", 8'h00, 32'h1, 32'h1), 1, 0);
    send_entry(short_entry("TWO        ", 8'h00, 32'h1, 32'h1), 0, 0);
    send_entry(lfn_text("Third entry!X"), 0, 0);
    send_entry(short_entry("THREE   DAT", 8'h04, 32'hABCD_0123, 32'h10), 0, 0);

    // The receiver holds off while many one-item scans pile up.
    set_wanted(16'd0);
    hold_req = 1;
    calm = 1;
    repeat (24) send_entry(256'h0, 1, 0);
    calm = 0;

    // Random phases.
    random_scan(0, 1);
    while (sent_cnt < ItemGoal) begin
      ws = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
      set_wanted(ws);
      repeat ($urandom_range(1, 3)) begin
        calm = ($urandom_range(0, 4) == 0);
        random_scan($urandom_range(0, 6), 0);
      end
      calm = 0;
    end
    in_valid <= 1'b0;

    wait (dir_results_q.size() == 0);
    repeat (80) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
rtl/fdes_pkg.sv
rtl/fdes_name_ram.sv
rtl/fat_directory_entry_scanner_unit.sv
bench/testbench.sv
